// ===== hdl/llss_pkg.sv =====
// ----------------------------------------------------------------------------
// Least-loaded server selector package
// Shared constants, event codes and the table-to-compare-unit slot view type.
// ----------------------------------------------------------------------------
`default_nettype none

package llss_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 40;
   localparam int CNT_W      = 20;
   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;

   localparam logic [CNT_W-1:0] HB_RESET   = CNT_W'(5000);
   localparam logic [CNT_W-1:0] SIL_RESET  = CNT_W'(30000);
   localparam logic [CNT_W-1:0] LOAD_MAX   = {CNT_W{1'b1}};

   // Event codes carried in the func field.
   localparam logic [2:0] FUNC_CONNECT    = 3'd0;
   localparam logic [2:0] FUNC_INFO       = 3'd1;
   localparam logic [2:0] FUNC_DISCONNECT = 3'd2;
   localparam logic [2:0] FUNC_RECEIVED   = 3'd3;
   localparam logic [2:0] FUNC_SENT       = 3'd4;
   localparam logic [2:0] FUNC_UPDATE     = 3'd5;
   localparam logic [2:0] FUNC_REQUEST    = 3'd6;
   localparam logic [2:0] FUNC_TICK       = 3'd7;

   // Refusal codes of a request response.
   localparam logic [1:0] REFUSE_NONE = 2'd0;
   localparam logic [1:0] REFUSE_EMPTY = 2'd1;
   localparam logic [1:0] REFUSE_FULL  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_HEARTBEAT = 1'b0;
   localparam logic CSR_SILENCE   = 1'b1;

   // Per-slot values read from the slot table for the shared compare unit.
   typedef struct packed {
      logic              valid;
      logic [CNT_W-1:0]  capacity;
      logic [CNT_W-1:0]  load;
      logic [TIME_W-1:0] sent;
      logic [TIME_W-1:0] heard;
   } slot_view_type;

endpackage

`default_nettype wire

// ===== hdl/llss_table.sv =====
// ----------------------------------------------------------------------------
// Least-loaded server selector slot table
// Holds the per-slot state, applies single-slot events and offers one slot
// at a time to the scanning sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module llss_table
   import llss_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                upd_en,
   input  wire logic [2:0]          upd_func,
   input  wire logic [SLOT_W-1:0]   upd_slot,
   input  wire logic [TIME_W-1:0]   upd_now,
   input  wire logic [ADDR_W-1:0]   upd_primary,
   input  wire logic [ADDR_W-1:0]   upd_backup,
   input  wire logic [PORT_W-1:0]   upd_port,
   input  wire logic [CNT_W-1:0]    upd_max,
   input  wire logic [CNT_W-1:0]    upd_cur,
   input  wire logic                upd_join,
   input  wire logic [SLOT_W-1:0]   scan_slot,
   output slot_view_type            scan_view,
   input  wire logic [SLOT_W-1:0]   pick_slot,
   output logic [ADDR_W-1:0]        pick_primary,
   output logic [ADDR_W-1:0]        pick_backup,
   output logic [PORT_W-1:0]        pick_port
);

   logic [SLOT_COUNT-1:0] valid_ff;
   logic [ADDR_W-1:0]     primary_ff [SLOT_COUNT];
   logic [ADDR_W-1:0]     backup_ff  [SLOT_COUNT];
   logic [PORT_W-1:0]     port_ff    [SLOT_COUNT];
   logic [CNT_W-1:0]      cap_ff     [SLOT_COUNT];
   logic [CNT_W-1:0]      load_ff    [SLOT_COUNT];
   logic [TIME_W-1:0]     sent_ff    [SLOT_COUNT];
   logic [TIME_W-1:0]     heard_ff   [SLOT_COUNT];

   logic in_table;
   logic hit;

   assign in_table = (32'(upd_slot) < SLOT_COUNT);
   assign hit      = upd_en && in_table && valid_ff[upd_slot];

   // Valid bits are control state and clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (upd_en && in_table) begin
         if (upd_func == FUNC_CONNECT) begin
            valid_ff[upd_slot] <= 1'b1;
         end else if (upd_func == FUNC_DISCONNECT) begin
            valid_ff[upd_slot] <= 1'b0;
         end
      end
   end

   // Slot payload; only the values of valid slots are ever used.
   always_ff @(posedge clock) begin
      if (upd_en && in_table && upd_func == FUNC_CONNECT) begin
         primary_ff[upd_slot] <= '0;
         backup_ff[upd_slot]  <= '0;
         port_ff[upd_slot]    <= '0;
         cap_ff[upd_slot]     <= '0;
         load_ff[upd_slot]    <= '0;
         sent_ff[upd_slot]    <= upd_now;
         heard_ff[upd_slot]   <= upd_now;
      end else if (hit) begin
         case (upd_func)
            FUNC_INFO: begin
               primary_ff[upd_slot] <= upd_primary;
               backup_ff[upd_slot]  <= upd_backup;
               port_ff[upd_slot]    <= upd_port;
               cap_ff[upd_slot]     <= upd_max;
               load_ff[upd_slot]    <= upd_cur;
            end
            FUNC_RECEIVED: heard_ff[upd_slot] <= upd_now;
            FUNC_SENT:     sent_ff[upd_slot]  <= upd_now;
            FUNC_UPDATE: begin
               if (upd_join) begin
                  if (load_ff[upd_slot] != LOAD_MAX) begin
                     load_ff[upd_slot] <= load_ff[upd_slot] + 1'b1;
                  end
               end else if (load_ff[upd_slot] != '0) begin
                  load_ff[upd_slot] <= load_ff[upd_slot] - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // One slot per cycle goes to the compare unit, unless a tick scan is held by a stalled result channel.
   always_comb begin
      scan_view.valid    = valid_ff[scan_slot];
      scan_view.capacity = cap_ff[scan_slot];
      scan_view.load     = load_ff[scan_slot];
      scan_view.sent     = sent_ff[scan_slot];
      scan_view.heard    = heard_ff[scan_slot];
   end

   assign pick_primary = primary_ff[pick_slot];
   assign pick_backup  = backup_ff[pick_slot];
   assign pick_port    = port_ff[pick_slot];

endmodule

`default_nettype wire

// ===== hdl/least_loaded_server_selector.sv =====
// ----------------------------------------------------------------------------
// Least-loaded server selector
// Sequencer and shared compare unit over a table of server slots.
// ----------------------------------------------------------------------------
// Single-slot events (connect, info, disconnect, received, sent, user update)
// pass through the update state and back to idle. A request or a tick scans
// the slots one per cycle through one shared compare unit, unless a tick scan is
// held by a stalled result channel; a tick gives one transaction per valid slot.
// The block takes no new transaction while an event is in progress.
`default_nettype none

module least_loaded_server_selector
   import llss_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_func,
   input  wire logic [SLOT_W-1:0]   req_slot,
   input  wire logic [TIME_W-1:0]   req_now_time,
   input  wire logic [ADDR_W-1:0]   req_ip_primary,
   input  wire logic [ADDR_W-1:0]   req_ip_backup,
   input  wire logic [PORT_W-1:0]   req_server_port,
   input  wire logic [CNT_W-1:0]    req_max_users,
   input  wire logic [CNT_W-1:0]    req_cur_users,
   input  wire logic                req_user_join,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_result_kind,
   output logic [1:0]               rsp_refuse_code,
   output logic [ADDR_W-1:0]        rsp_chosen_primary,
   output logic [ADDR_W-1:0]        rsp_chosen_backup,
   output logic [PORT_W-1:0]        rsp_chosen_port,
   output logic [SLOT_W-1:0]        rsp_action_slot,
   output logic                     rsp_send_heartbeat,
   output logic                     rsp_force_close,
   output logic                     rsp_last_of_run,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [CNT_W-1:0]    csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_TICK_OUT,
      ST_REQ_OUT,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           func_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [ADDR_W-1:0]    pri_ff, bak_ff;
   logic [PORT_W-1:0]    port_ff;
   logic [CNT_W-1:0]     max_ff, cur_ff;
   logic                 join_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic                 any_ff, found_ff;
   logic [SLOT_W-1:0]    best_ff;
   logic [CNT_W-1:0]     best_load_ff;
   logic [CNT_W-1:0]     hb_ff, sil_ff;

   // Held tick action waiting for the next valid slot to learn last_of_run.
   logic                 pend_ff;
   logic [SLOT_W-1:0]    pend_slot_ff;
   logic                 pend_hb_ff, pend_fc_ff;

   logic                 out_valid_ff;
   logic                 out_kind_ff;
   logic [1:0]           out_code_ff;
   logic [SLOT_W-1:0]    out_slot_ff;
   logic                 out_hb_ff, out_fc_ff, out_last_ff;
   logic [SLOT_W-1:0]    out_pick_ff;

   slot_view_type        view;
   logic [ADDR_W-1:0]    pick_pri, pick_bak;
   logic [PORT_W-1:0]    pick_port;
   logic                 accept;
   logic                 out_free;
   logic                 out_load;
   logic                 scan_end;
   logic                 hb_due, fc_due;
   logic                 better;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign scan_end  = (32'(idx_ff) == SLOT_COUNT - 1);

   // The output register takes a new result in this cycle.
   assign out_load  = (state_ff == ST_SCAN && func_ff == FUNC_TICK && view.valid &&
                       pend_ff && out_free) ||
                      (state_ff == ST_TICK_OUT && pend_ff && out_free) ||
                      (state_ff == ST_REQ_OUT && out_free);

   llss_table u_table (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (state_ff == ST_UPDATE),
      .upd_func     (func_ff),
      .upd_slot     (slot_ff),
      .upd_now      (now_ff),
      .upd_primary  (pri_ff),
      .upd_backup   (bak_ff),
      .upd_port     (port_ff),
      .upd_max      (max_ff),
      .upd_cur      (cur_ff),
      .upd_join     (join_ff),
      .scan_slot    (idx_ff),
      .scan_view    (view),
      .pick_slot    (out_pick_ff),
      .pick_primary (pick_pri),
      .pick_backup  (pick_bak),
      .pick_port    (pick_port)
   );

   // Shared compare unit: one slot per cycle while the scan is not held. The sums carry one extra bit.
   assign hb_due = {1'b0, now_ff} > ({1'b0, view.sent} + (TIME_W+1)'(hb_ff));
   assign fc_due = {1'b0, now_ff} > ({1'b0, view.heard} + (TIME_W+1)'(sil_ff));
   assign better = (view.load < view.capacity) &&
                   (!found_ff || view.load < best_load_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_REQUEST || req_func == FUNC_TICK) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (func_ff == FUNC_TICK && view.valid && pend_ff && !out_free) begin
               state_in = ST_SCAN;
            end else if (scan_end) begin
               state_in = (func_ff == FUNC_TICK) ? ST_TICK_OUT : ST_REQ_OUT;
            end
         end
         ST_TICK_OUT: if (!pend_ff || out_free) state_in = ST_FLUSH;
         ST_REQ_OUT:  if (out_free) state_in = ST_FLUSH;
         ST_FLUSH:    if (!out_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         hb_ff        <= HB_RESET;
         sil_ff       <= SIL_RESET;
         idx_ff       <= '0;
         any_ff       <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && !rsp_stall && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEARTBEAT) hb_ff <= csr_data;
            else sil_ff <= csr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               idx_ff   <= '0;
               any_ff   <= 1'b0;
               found_ff <= 1'b0;
               pend_ff  <= 1'b0;
            end
            ST_SCAN: begin
               if (func_ff == FUNC_TICK) begin
                  if (view.valid) begin
                     if (!pend_ff || out_free) begin
                        if (pend_ff) begin
                           out_valid_ff <= 1'b1;
                           out_kind_ff  <= 1'b1;
                           out_code_ff  <= REFUSE_NONE;
                           out_slot_ff  <= pend_slot_ff;
                           out_hb_ff    <= pend_hb_ff;
                           out_fc_ff    <= pend_fc_ff;
                           out_last_ff  <= 1'b0;
                        end
                        pend_ff      <= 1'b1;
                        pend_slot_ff <= idx_ff;
                        pend_hb_ff   <= hb_due;
                        pend_fc_ff   <= fc_due;
                        idx_ff       <= idx_ff + 1'b1;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  if (view.valid) begin
                     any_ff <= 1'b1;
                     if (better) begin
                        found_ff     <= 1'b1;
                        best_ff      <= idx_ff;
                        best_load_ff <= view.load;
                     end
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_TICK_OUT: begin
               if (pend_ff && out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= 1'b1;
                  out_code_ff  <= REFUSE_NONE;
                  out_slot_ff  <= pend_slot_ff;
                  out_hb_ff    <= pend_hb_ff;
                  out_fc_ff    <= pend_fc_ff;
                  out_last_ff  <= 1'b1;
                  pend_ff      <= 1'b0;
               end
            end
            ST_REQ_OUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= 1'b0;
                  out_code_ff  <= !any_ff ? REFUSE_EMPTY :
                                  (!found_ff ? REFUSE_FULL : REFUSE_NONE);
                  out_pick_ff  <= best_ff;
                  out_slot_ff  <= '0;
                  out_hb_ff    <= 1'b0;
                  out_fc_ff    <= 1'b0;
                  out_last_ff  <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Capture of the accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         slot_ff <= req_slot;
         now_ff  <= req_now_time;
         pri_ff  <= req_ip_primary;
         bak_ff  <= req_ip_backup;
         port_ff <= req_server_port;
         max_ff  <= req_max_users;
         cur_ff  <= req_cur_users;
         join_ff <= req_user_join;
      end
   end

   // Chosen server data comes from the table only for an assigned request.
   logic assigned;
   assign assigned           = !out_kind_ff && (out_code_ff == REFUSE_NONE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_refuse_code    = out_code_ff;
   assign rsp_chosen_primary = assigned ? pick_pri : '0;
   assign rsp_chosen_backup  = assigned ? pick_bak : '0;
   assign rsp_chosen_port    = assigned ? pick_port : '0;
   assign rsp_action_slot    = out_slot_ff;
   assign rsp_send_heartbeat = out_hb_ff;
   assign rsp_force_close    = out_fc_ff;
   assign rsp_last_of_run    = out_last_ff;

   // The block never takes a transaction while busy.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("transaction accepted while busy");

   // A result overwritten before it was taken would be lost.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_slot_ff)
                                       && $stable(out_last_ff)))
      else $error("held result changed");

   // A request response always ends its run.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_kind_ff) |-> out_last_ff)
      else $error("request response without last flag");

endmodule

`default_nettype wire
